[rtl/sit_pkg.sv]
// ---------------------------------------------------------------------------
// sit_pkg: shared types and constants of the string intern table
// Sizes, widths, status codes and the item type carried between front
// and back end.
// ---------------------------------------------------------------------------
package sit_pkg;

    localparam int ENTRIES        = 256;
    localparam int STORE_BYTES    = 4096;
    localparam int MAX_NAME_BYTES = 64;
    localparam int QUEUE_DEPTH    = 4;

    localparam int ENT_AW  = $clog2(ENTRIES);
    localparam int ID_W    = $clog2(ENTRIES + 1);
    localparam int ST_AW   = $clog2(STORE_BYTES);
    localparam int USED_W  = $clog2(STORE_BYTES + 1);
    localparam int PN_AW   = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;
    localparam int PLEN_W  = $clog2(MAX_NAME_BYTES + 1);
    localparam int QA_W    = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] CMD_NAME  = 2'd0;
    localparam logic [1:0] CMD_QUERY = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    typedef logic [2:0] status_t;
    localparam status_t ST_FOUND   = 3'd0;
    localparam status_t ST_ADDED   = 3'd1;
    localparam status_t ST_FULL    = 3'd2;
    localparam status_t ST_NOSPACE = 3'd3;
    localparam status_t ST_TOOLONG = 3'd4;
    localparam status_t ST_INVALID = 3'd5;

    typedef enum logic [1:0] {
        OP_NAME  = 2'd0,
        OP_QUERY = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       data_byte;
        logic             has_byte;
        logic             is_last;
        logic [8:0]       query_id;
        logic [11:0]      address;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [8:0]  result_id;
        logic [11:0] entry_start;
        logic [6:0]  entry_size;
        logic [7:0]  read_data;
    } res_t;

endpackage

[rtl/sit_front.sv]
// ---------------------------------------------------------------------------
// sit_front: input classifier
// Decodes the incoming command into an operation and drops items that
// have no effect.
// ---------------------------------------------------------------------------
module sit_front (
    input  logic           push,
    input  logic [1:0]     command,
    input  logic [7:0]     data_byte,
    input  logic           has_byte,
    input  logic           is_last,
    input  logic [8:0]     query_id,
    input  logic [11:0]    address,
    input  logic           q_full,
    output logic           q_push,
    output sit_pkg::item_t q_item
);
    import sit_pkg::*;

    logic keep;

    always_comb
    begin
        keep         = 1'b1;
        q_item.op    = OP_NAME;
        case (command)
            CMD_NAME:  q_item.op = OP_NAME;
            CMD_QUERY: q_item.op = OP_QUERY;
            CMD_READ:  q_item.op = OP_READ;
            default:   keep = 1'b0;
        endcase
        // A name item with neither a byte nor the last mark changes nothing.
        if (command == CMD_NAME && !has_byte && !is_last)
        begin
            keep = 1'b0;
        end
        q_item.data_byte = data_byte;
        q_item.has_byte  = has_byte;
        q_item.is_last   = is_last;
        q_item.query_id  = query_id;
        q_item.address   = address;
    end

    assign q_push = push && !q_full && keep;

endmodule

[rtl/sit_queue.sv]
// ---------------------------------------------------------------------------
// sit_queue: item queue between front and back end
// A small register FIFO that lets the input side run ahead of lookups.
// ---------------------------------------------------------------------------
module sit_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  sit_pkg::item_t wr_item,
    input  logic           rd_en,
    output sit_pkg::item_t rd_item,
    output logic           q_full,
    output logic           q_empty
);
    import sit_pkg::*;

    item_t            mem [QUEUE_DEPTH];
    logic [QA_W-1:0]  wptr_reg, wptr_next;
    logic [QA_W-1:0]  rptr_reg, rptr_next;
    logic [QA_W:0]    cnt_reg, cnt_next;

    assign q_full  = (cnt_reg == (QA_W+1)'(QUEUE_DEPTH));
    assign q_empty = (cnt_reg == '0);
    assign rd_item = mem[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (wr_en)
        begin
            wptr_next = wptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rptr_next = rptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

[rtl/sit_back.sv]
// ---------------------------------------------------------------------------
// sit_back: lookup and insert engine
// Holds the pending name, the entry table and the byte store, runs the
// entry scan, the byte compare and the copy, and drives the result register.
// ---------------------------------------------------------------------------
module sit_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_empty,
    input  sit_pkg::item_t q_item,
    output logic           q_pop,
    input  logic           pop,
    output logic           out_valid,
    output sit_pkg::res_t  out_res
);
    import sit_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_ERD     = 12'b000000000010,
        S_ECHK    = 12'b000000000100,
        S_BRD     = 12'b000000001000,
        S_BCHK    = 12'b000000010000,
        S_NOMATCH = 12'b000000100000,
        S_CRD     = 12'b000001000000,
        S_CWR     = 12'b000010000000,
        S_EWR     = 12'b000100000000,
        S_QCHK    = 12'b001000000000,
        S_RCHK    = 12'b010000000000,
        S_RESP    = 12'b100000000000
    } state_t;

    typedef struct packed {
        logic [ST_AW-1:0]  off;
        logic [PLEN_W-1:0] len;
    } ent_t;

    ent_t       ent_mem   [ENTRIES];
    logic [7:0] store_mem [STORE_BYTES];
    logic [7:0] pend_mem  [MAX_NAME_BYTES];

    state_t             state_reg, state_next;
    op_t                op_reg, op_next;
    logic [ENT_AW-1:0]  idx_reg, idx_next;
    logic [PN_AW-1:0]   k_reg, k_next;
    logic [ST_AW-1:0]   off_reg, off_next;
    logic [ID_W-1:0]    count_reg, count_next;
    logic [USED_W-1:0]  used_reg, used_next;
    logic [PLEN_W-1:0]  plen_reg, plen_next;
    logic               ovf_reg, ovf_next;
    res_t               res_reg, res_next;
    logic               out_valid_reg, out_valid_next;
    res_t               out_reg, out_next;

    logic [ENT_AW-1:0]  ent_raddr;
    ent_t               ent_q;
    logic               ent_we;
    ent_t               ent_wdata;
    logic [ST_AW-1:0]   st_raddr;
    logic [7:0]         st_q;
    logic               st_we;
    logic [ST_AW-1:0]   st_waddr;
    logic [PN_AW-1:0]   pn_raddr;
    logic [7:0]         pn_q;
    logic               pn_we;
    logic [PN_AW-1:0]   pn_waddr;
    logic               last_entry;
    logic               last_byte;
    logic [USED_W:0]    need;

    assign last_entry = (({1'b0, idx_reg} + 1'b1) == count_reg);
    assign last_byte  = (({1'b0, k_reg} + 1'b1) == plen_reg);
    assign need       = {1'b0, used_reg} + (USED_W+1)'(plen_reg);

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        k_next         = k_reg;
        off_next       = off_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        plen_next      = plen_reg;
        ovf_next       = ovf_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !pop;
        out_next       = out_reg;
        q_pop          = 1'b0;
        ent_raddr      = idx_reg;
        ent_we         = 1'b0;
        ent_wdata      = '{off: used_reg[ST_AW-1:0], len: plen_reg};
        st_raddr       = off_reg + ST_AW'(k_reg);
        st_we          = 1'b0;
        st_waddr       = used_reg[ST_AW-1:0] + ST_AW'(k_reg);
        pn_raddr       = k_reg;
        pn_we          = 1'b0;
        pn_waddr       = plen_reg[PN_AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                res_next = '0;
                if (!q_empty)
                begin
                    q_pop   = 1'b1;
                    op_next = q_item.op;
                    case (q_item.op)
                        OP_NAME:
                        begin
                            if (q_item.has_byte)
                            begin
                                if (plen_reg < PLEN_W'(MAX_NAME_BYTES))
                                begin
                                    pn_we     = 1'b1;
                                    plen_next = plen_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                            if (q_item.is_last)
                            begin
                                idx_next = '0;
                                if (ovf_next)
                                begin
                                    res_next.status = ST_TOOLONG;
                                    state_next      = S_RESP;
                                end
                                else if (count_reg == '0)
                                begin
                                    state_next = S_NOMATCH;
                                end
                                else
                                begin
                                    state_next = S_ERD;
                                end
                            end
                        end
                        OP_QUERY:
                        begin
                            ent_raddr = ENT_AW'(q_item.query_id - 1'b1);
                            if (q_item.query_id == '0 || q_item.query_id > count_reg)
                            begin
                                res_next.status = ST_INVALID;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                res_next.result_id = q_item.query_id;
                                state_next         = S_QCHK;
                            end
                        end
                        OP_READ:
                        begin
                            st_raddr = q_item.address;
                            if ({1'b0, q_item.address} >= used_reg)
                            begin
                                res_next.status = ST_INVALID;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                state_next = S_RCHK;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ERD:
            begin
                state_next = S_ECHK;
            end
            S_ECHK:
            begin
                if (ent_q.len == plen_reg)
                begin
                    if (plen_reg == '0)
                    begin
                        res_next.status    = ST_FOUND;
                        res_next.result_id = {1'b0, idx_reg} + 1'b1;
                        state_next         = S_RESP;
                    end
                    else
                    begin
                        off_next   = ent_q.off;
                        k_next     = '0;
                        state_next = S_BRD;
                    end
                end
                else if (last_entry)
                begin
                    state_next = S_NOMATCH;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_ERD;
                end
            end
            S_BRD:
            begin
                state_next = S_BCHK;
            end
            S_BCHK:
            begin
                if (st_q == pn_q)
                begin
                    if (last_byte)
                    begin
                        res_next.status    = ST_FOUND;
                        res_next.result_id = {1'b0, idx_reg} + 1'b1;
                        state_next         = S_RESP;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_BRD;
                    end
                end
                else if (last_entry)
                begin
                    state_next = S_NOMATCH;
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_ERD;
                end
            end
            S_NOMATCH:
            begin
                k_next = '0;
                if (count_reg == ID_W'(ENTRIES))
                begin
                    res_next.status = ST_FULL;
                    state_next      = S_RESP;
                end
                else if (need > (USED_W+1)'(STORE_BYTES))
                begin
                    res_next.status = ST_NOSPACE;
                    state_next      = S_RESP;
                end
                else if (plen_reg == '0)
                begin
                    state_next = S_EWR;
                end
                else
                begin
                    state_next = S_CRD;
                end
            end
            S_CRD:
            begin
                state_next = S_CWR;
            end
            S_CWR:
            begin
                st_we = 1'b1;
                if (last_byte)
                begin
                    state_next = S_EWR;
                end
                else
                begin
                    k_next     = k_reg + 1'b1;
                    state_next = S_CRD;
                end
            end
            S_EWR:
            begin
                ent_raddr          = count_reg[ENT_AW-1:0];
                ent_we             = 1'b1;
                count_next         = count_reg + 1'b1;
                used_next          = used_reg + USED_W'(plen_reg);
                res_next.status    = ST_ADDED;
                res_next.result_id = count_reg + 1'b1;
                state_next         = S_RESP;
            end
            S_QCHK:
            begin
                res_next.status      = ST_FOUND;
                res_next.entry_start = ent_q.off;
                res_next.entry_size  = ent_q.len;
                state_next           = S_RESP;
            end
            S_RCHK:
            begin
                res_next.status    = ST_FOUND;
                res_next.read_data = st_q;
                state_next         = S_RESP;
            end
            S_RESP:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_valid_next = 1'b1;
                    out_next       = res_reg;
                    // A closed name always leaves an empty pending buffer.
                    if (op_reg == OP_NAME)
                    begin
                        plen_next = '0;
                        ovf_next  = 1'b0;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ent_we)
        begin
            ent_mem[count_reg[ENT_AW-1:0]] <= ent_wdata;
        end
        ent_q <= ent_mem[ent_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            store_mem[st_waddr] <= pn_q;
        end
        st_q <= store_mem[st_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (pn_we)
        begin
            pend_mem[pn_waddr] <= q_item.data_byte;
        end
        pn_q <= pend_mem[pn_raddr];
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        k_reg   <= k_next;
        off_reg <= off_next;
        res_reg <= res_next;
        out_reg <= out_next;
        op_reg  <= op_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            used_reg      <= '0;
            plen_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            plen_reg      <= plen_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[rtl/string_intern_table.sv]
// ---------------------------------------------------------------------------
// string_intern_table: name interning table with id lookup
// Streams name bytes, returns an id per distinct name, answers entry and
// byte queries.
// ---------------------------------------------------------------------------
// Input side is a queue: an item transfers when push is high and full low.
// Results come out as a queue: the oldest result sits on the result ports
// while empty is low and transfers when pop is high.
// A name byte not marked last is added to the pending name, or marks it too
// long once it is full, and gives no result. Entry and byte queries pass
// through a check state before the result state; an invalid id or address
// goes straight to the result state. A closing name item scans the stored
// entries, checking the length of each and comparing bytes one by one for
// entries of the same length; a new name is then copied byte by byte and
// its entry written. The scan over entry count and name length sets the
// rate; the four-deep item queue absorbs byte bursts.
// Reset empties the table, the byte store and the pending name. No clearing
// pass is needed. When the receiver stalls, one result is held on the ports,
// the next waits in the back end, and full rises once the item queue fills.
// ---------------------------------------------------------------------------
module string_intern_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        is_last,
    input  logic [8:0]  query_id,
    input  logic [11:0] address,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  status,
    output logic [8:0]  result_id,
    output logic [11:0] entry_start,
    output logic [6:0]  entry_size,
    output logic [7:0]  read_data
);
    import sit_pkg::*;

    item_t fr_item;
    item_t bk_item;
    logic  fr_push;
    logic  bk_pop;
    logic  q_full;
    logic  q_empty;
    logic  out_valid;
    res_t  out_res;

    sit_front u_front (
        .push      (push),
        .command   (command),
        .data_byte (data_byte),
        .has_byte  (has_byte),
        .is_last   (is_last),
        .query_id  (query_id),
        .address   (address),
        .q_full    (q_full),
        .q_push    (fr_push),
        .q_item    (fr_item)
    );

    sit_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (fr_push),
        .wr_item (fr_item),
        .rd_en   (bk_pop),
        .rd_item (bk_item),
        .q_full  (q_full),
        .q_empty (q_empty)
    );

    sit_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_item    (bk_item),
        .q_pop     (bk_pop),
        .pop       (pop),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign full        = q_full;
    assign empty       = !out_valid;
    assign status      = out_res.status;
    assign result_id   = out_res.result_id;
    assign entry_start = out_res.entry_start;
    assign entry_size  = out_res.entry_size;
    assign read_data   = out_res.read_data;

    // The queue is never full and empty at once.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_full && q_empty))
        else $error("item queue reports full and empty together");

    // The back end never takes an item from an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) bk_pop |-> !q_empty)
        else $error("back end popped an empty queue");

    // An added name always carries a nonzero id.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_ADDED) |-> (result_id != '0))
        else $error("added name has id zero");

    // Failures carry no id.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == ST_FULL || status == ST_NOSPACE ||
                    status == ST_TOOLONG || status == ST_INVALID)) |-> (result_id == '0))
        else $error("failed result carries an id");

endmodule

[sim/intern_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// intern_checker: prediction and comparison for the string intern table
// Watches both queue sides, keeps its own copy of the table and byte store,
// and compares every result transfer field by field with the oldest
// predicted reply.
// ---------------------------------------------------------------------------
module intern_checker
    import sit_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  command,
    input  logic [7:0]  data_byte,
    input  logic        has_byte,
    input  logic        is_last,
    input  logic [8:0]  query_id,
    input  logic [11:0] address,
    input  logic        empty,
    input  logic        pop,
    input  logic [2:0]  status,
    input  logic [8:0]  result_id,
    input  logic [11:0] entry_start,
    input  logic [6:0]  entry_size,
    input  logic [7:0]  read_data,
    output int          errors,
    output int          outstanding,
    output int          stored_names,
    output int          bytes_taken
);

    logic [11:0] name_offset [ENTRIES];
    logic [6:0]  name_length [ENTRIES];
    logic [7:0]  store_mem   [STORE_BYTES];
    logic [7:0]  partial_name [MAX_NAME_BYTES];
    int          partial_len;
    bit          partial_overflow;
    res_t        awaited_replies [$];

    assign outstanding = awaited_replies.size();

    // Lookup or insert of the name collected so far.
    function automatic res_t close_name();
        res_t r;
        bit   same;
        r = '0;
        if (partial_overflow) begin
            r.status = ST_TOOLONG;
            return r;
        end
        for (int i = 0; i < stored_names; i++) begin
            if (name_length[i] == partial_len) begin
                same = 1;
                for (int k = 0; k < partial_len; k++)
                    if (store_mem[name_offset[i] + k] != partial_name[k])
                        same = 0;
                if (same) begin
                    r.status = ST_FOUND;
                    r.result_id = 9'(i + 1);
                    return r;
                end
            end
        end
        if (stored_names >= ENTRIES) begin
            r.status = ST_FULL;
            return r;
        end
        if (partial_len > STORE_BYTES - bytes_taken) begin
            r.status = ST_NOSPACE;
            return r;
        end
        for (int k = 0; k < partial_len; k++)
            store_mem[bytes_taken + k] = partial_name[k];
        name_offset[stored_names] = 12'(bytes_taken);
        name_length[stored_names] = 7'(partial_len);
        stored_names++;
        bytes_taken += partial_len;
        r.status = ST_ADDED;
        r.result_id = 9'(stored_names);
        return r;
    endfunction

    task automatic predict_intern();
        res_t r;
        r = '0;
        case (command)
            CMD_NAME:
            begin
                if (has_byte) begin
                    if (partial_len < MAX_NAME_BYTES) begin
                        partial_name[partial_len] = data_byte;
                        partial_len++;
                    end else begin
                        partial_overflow = 1;
                    end
                end
                if (is_last) begin
                    awaited_replies.push_back(close_name());
                    partial_len = 0;
                    partial_overflow = 0;
                end
            end
            CMD_QUERY:
            begin
                if (query_id == 0 || query_id > stored_names) begin
                    r.status = ST_INVALID;
                end else begin
                    r.status = ST_FOUND;
                    r.result_id = query_id;
                    r.entry_start = name_offset[query_id - 1];
                    r.entry_size = name_length[query_id - 1];
                end
                awaited_replies.push_back(r);
            end
            CMD_READ:
            begin
                if (address >= bytes_taken)
                    r.status = ST_INVALID;
                else
                    r.read_data = store_mem[address];
                awaited_replies.push_back(r);
            end
            default:
            begin
            end
        endcase
    endtask

    task automatic compare_reply();
        res_t e;
        if (awaited_replies.size() == 0) begin
            $error("result transfer with no reply expected");
            errors++;
            return;
        end
        e = awaited_replies.pop_front();
        if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            errors++;
        end
        if (result_id !== e.result_id) begin
            $error("result_id: expected %0d, actual %0d", e.result_id, result_id);
            errors++;
        end
        if (entry_start !== e.entry_start) begin
            $error("entry_start: expected %0d, actual %0d", e.entry_start, entry_start);
            errors++;
        end
        if (entry_size !== e.entry_size) begin
            $error("entry_size: expected %0d, actual %0d", e.entry_size, entry_size);
            errors++;
        end
        if (read_data !== e.read_data) begin
            $error("read_data: expected %0d, actual %0d", e.read_data, read_data);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            errors = 0;
            stored_names = 0;
            bytes_taken = 0;
            partial_len = 0;
            partial_overflow = 0;
            awaited_replies.delete();
        end else begin
            if (pop && !empty)
                compare_reply();
            if (push && !full)
                predict_intern();
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top: testbench of the string intern table
// Directed names and queries, then random traffic with matches, overflows
// and interleaved reads, then a steered fill that runs out of byte space
// and then out of table entries.
// ---------------------------------------------------------------------------
module tb_top;
    import sit_pkg::*;

    localparam int IDLE_LIMIT = 100000;

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic        has_byte;
    logic        is_last;
    logic [8:0]  query_id;
    logic [11:0] address;
    logic        empty;
    logic        pop;
    logic [2:0]  status;
    logic [8:0]  result_id;
    logic [11:0] entry_start;
    logic [6:0]  entry_size;
    logic [7:0]  read_data;

    int errors, outstanding, stored_names, bytes_taken;
    int sent;
    int quiet_cycles = 0;
    bit calm;
    bit held_once;
    int fill_tag;

    string_intern_table dut (.*);

    intern_checker checker_i (.*);

    always begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    initial begin
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        command = CMD_NAME;
        data_byte = '0;
        has_byte = 1'b0;
        is_last = 1'b0;
        query_id = '0;
        address = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Receiver: random stall bursts, one long hold-off while items keep coming.
    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!held_once && sent > 300) begin
                held_once = 1;
                pop = 1'b0;
                repeat (300) @(negedge clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                pop = 1'b0;
                repeat ($urandom_range(0, 2)) @(negedge clk);
            end else begin
                pop = 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] db, input logic hb,
                             input logic il, input logic [8:0] qid, input logic [11:0] addr);
        if (!calm && $urandom_range(0, 9) == 0) begin
            @(negedge clk);
            push = 1'b0;
            repeat ($urandom_range(0, 2)) @(negedge clk);
        end
        @(negedge clk);
        command = cmd;
        data_byte = db;
        has_byte = hb;
        is_last = il;
        query_id = qid;
        address = addr;
        push = 1'b1;
        while (full)
            @(negedge clk);
        sent++;
    endtask

    task automatic random_query();
        logic [8:0] qid;
        qid = ($urandom_range(0, 9) < 7) ? 9'($urandom_range(0, stored_names + 2))
                                          : 9'($urandom_range(0, 511));
        send_item(CMD_QUERY, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), qid, 12'($urandom_range(0, 4095)));
    endtask

    task automatic random_read();
        logic [11:0] addr;
        addr = ($urandom_range(0, 9) < 7 && bytes_taken > 0)
               ? 12'($urandom_range(0, bytes_taken - 1)) : 12'($urandom_range(0, 4095));
        send_item(CMD_READ, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)), addr);
    endtask

    // Streams one name; random names never start with 0xFF, so fill names stay new.
    task automatic send_name(input logic [7:0] bytes_in [$], input bit noisy);
        bit tail_item;
        tail_item = (bytes_in.size() == 0) || (noisy && $urandom_range(0, 9) == 0);
        foreach (bytes_in[k]) begin
            if (noisy && $urandom_range(0, 12) == 0)
                send_item(CMD_NAME, 8'($urandom_range(0, 255)), 1'b0, 1'b0,
                          9'($urandom_range(0, 511)), 12'($urandom_range(0, 4095)));
            if (noisy && $urandom_range(0, 19) == 0) begin
                if ($urandom_range(0, 1))
                    random_query();
                else
                    random_read();
            end
            send_item(CMD_NAME, bytes_in[k], 1'b1,
                      !tail_item && k == bytes_in.size() - 1,
                      9'($urandom_range(0, 511)), 12'($urandom_range(0, 4095)));
        end
        if (tail_item)
            send_item(CMD_NAME, 8'($urandom_range(0, 255)), 1'b0, 1'b1,
                      9'($urandom_range(0, 511)), 12'($urandom_range(0, 4095)));
    endtask

    task automatic random_name();
        logic [7:0] nm [$];
        int p, len;
        p = $urandom_range(0, 99);
        if (p < 3)
            len = 0;
        else if (p < 70)
            len = $urandom_range(1, 4);
        else if (p < 88)
            len = $urandom_range(5, 40);
        else
            len = $urandom_range(62, 67);
        for (int k = 0; k < len; k++) begin
            if (p < 70)
                nm.push_back(8'(8'h41 + $urandom_range(0, 3)));
            else if (k == 0)
                nm.push_back(8'($urandom_range(0, 254)));
            else
                nm.push_back(8'($urandom_range(0, 255)));
        end
        send_name(nm, 1);
    endtask

    // A name that no earlier name can equal: 0xFF, a unique tag, then fill.
    task automatic fresh_name(input int len);
        logic [7:0] nm [$];
        nm.push_back(8'hFF);
        if (len > 1)
            nm.push_back(fill_tag[7:0]);
        for (int k = 2; k < len; k++)
            nm.push_back(8'($urandom_range(0, 255)));
        fill_tag++;
        send_name(nm, 0);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        push = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    initial begin
        logic [7:0] nm [$];
        int slack, remaining;
        sent = 0;
        calm = 0;
        fill_tag = 0;
        @(posedge rst_n);

        // Directed: lookups on an empty table, the empty name, repeats.
        send_item(CMD_QUERY, 8'h00, 1'b0, 1'b0, 9'd0, 12'd0);
        send_item(CMD_QUERY, 8'h00, 1'b0, 1'b0, 9'd1, 12'd0);
        send_item(CMD_READ, 8'h00, 1'b0, 1'b0, 9'd0, 12'd0);
        send_item(CMD_NAME, 8'hFF, 1'b0, 1'b1, 9'd0, 12'd0);
        nm = '{8'h41};
        send_name(nm, 0);
        send_name(nm, 0);
        send_item(CMD_NAME, 8'hFF, 1'b0, 1'b1, 9'd0, 12'd0);
        send_item(CMD_NAME, 8'h42, 1'b1, 1'b0, 9'd0, 12'd0);
        send_item(CMD_QUERY, 8'h00, 1'b0, 1'b0, 9'd2, 12'd0);
        send_item(CMD_NAME, 8'h55, 1'b0, 1'b0, 9'd0, 12'd0);
        send_item(CMD_NAME, 8'hFF, 1'b1, 1'b0, 9'd0, 12'd0);
        send_item(CMD_READ, 8'h00, 1'b0, 1'b0, 9'd0, 12'd0);
        send_item(CMD_NAME, 8'h00, 1'b1, 1'b1, 9'd0, 12'd0);
        send_item(CMD_QUERY, 8'h00, 1'b0, 1'b0, 9'd3, 12'd0);
        send_item(CMD_QUERY, 8'h00, 1'b0, 1'b0, 9'd4, 12'd0);
        send_item(CMD_QUERY, 8'h00, 1'b0, 1'b0, 9'd511, 12'd0);
        send_item(CMD_READ, 8'h00, 1'b0, 1'b0, 9'd0, 12'd3);
        send_item(CMD_READ, 8'h00, 1'b0, 1'b0, 9'd0, 12'd4);
        send_item(CMD_READ, 8'h00, 1'b0, 1'b0, 9'd0, 12'd4095);
        send_item(2'd3, 8'hFF, 1'b1, 1'b1, 9'd511, 12'd4095);

        while (sent < 1150) begin
            case ($urandom_range(0, 19))
                0, 1, 2:
                    random_query();
                3, 4, 5:
                    random_read();
                6:
                    send_item(2'd3, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)),
                              12'($urandom_range(0, 4095)));
                default:
                    random_name();
            endcase
        end

        // Steered fill, no random stalls: keep room for two-byte names up to the
        // last entry, leave 63 bytes, then a 64-byte name cannot fit.
        calm = 1;
        wait_idle();
        while (ENTRIES - stored_names > 1) begin
            remaining = ENTRIES - stored_names;
            slack = (STORE_BYTES - bytes_taken) - 2 * (remaining - 1);
            if (slack > 125)
                fresh_name(64);
            else if (slack > 63)
                fresh_name(slack - 61);
            else
                fresh_name(2);
            wait_idle();
        end
        fresh_name(64);
        fresh_name(1);
        nm = '{8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_name(nm, 0);
        for (int k = 0; k < 6; k++) begin
            random_query();
            random_read();
        end

        wait_idle();
        if (errors == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
